@@ design/longest_pattern_repeat_run_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the longest pattern repeat run core
// Same-cycle and next-cycle implication checks, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef LONGEST_PATTERN_REPEAT_RUN_CORE_MACROS_SVH
`define LONGEST_PATTERN_REPEAT_RUN_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LPRR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lprr check failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define LPRR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lprr check failed: next-cycle implication");

`endif

@@ design/lprr_pkg.sv @@
// ---------------------------------------------------------------------------
// lprr_pkg
// Shared widths, register codes and control types of the pattern run core.
// ---------------------------------------------------------------------------
`default_nettype none

package lprr_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_W       = 64;
    localparam int LEN_W       = 4;
    localparam int RUN_W       = 17;
    localparam int START_OUT_W = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 64;

    // register index, taken from paddr[3] (registers sit at 8*i)
    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctl_t;

endpackage

`default_nettype wire

@@ design/lprr_window.sv @@
// ---------------------------------------------------------------------------
// lprr_window
// Recent-byte history and parallel compare of the newest window to the pattern.
// ---------------------------------------------------------------------------
`default_nettype none

module lprr_window #(
    parameter int MAX_PATTERN = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lprr_pkg::win_ctl_t            ctl,
    input  wire logic [lprr_pkg::BYTE_W-1:0]   byte_in,
    input  wire logic [lprr_pkg::PAT_W-1:0]    pattern,
    input  wire logic [lprr_pkg::LEN_W-1:0]    eff_len,
    output logic                               match
);

    localparam int PH_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [lprr_pkg::BYTE_W-1:0] recent_reg  [MAX_PATTERN];
    logic [lprr_pkg::BYTE_W-1:0] recent_next [MAX_PATTERN];

    // history as it stands once the incoming byte is in; entry 0 is newest
    always_comb begin
        recent_next[0] = byte_in;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            recent_next[i] = recent_reg[i-1];
        end
    end

    // window byte k sits at history slot len-1-k
    always_comb begin
        logic [lprr_pkg::LEN_W-1:0] idx;
        match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            idx = eff_len - lprr_pkg::LEN_W'(1) - lprr_pkg::LEN_W'(k);
            if (lprr_pkg::LEN_W'(k) < eff_len) begin
                if (recent_next[idx[PH_W-1:0]] != pattern[lprr_pkg::BYTE_W*k +: lprr_pkg::BYTE_W])
                begin
                    match = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                recent_reg[i] <= '0;
            end
        end else if (ctl.shift) begin
            recent_reg <= recent_next;
        end
    end

endmodule

`default_nettype wire

@@ design/longest_pattern_repeat_run_core.sv @@
// ---------------------------------------------------------------------------
// longest_pattern_repeat_run_core
// Longest run of back-to-back copies of a pattern in a streamed text.
// ---------------------------------------------------------------------------
// Usage:
//   Text enters one byte per beat on the s_ channel (valid/ready); the byte
//   flagged by s_end_of_text closes the text. For that byte one result beat
//   leaves on the m_ channel: longest run count, its zero-based start, a found
//   flag and a flag for bytes dropped past MAX_TEXT. Other bytes give no beat.
//   The pattern (up to eight bytes, little-endian) and its length are set over
//   the APB port at byte addresses 0 and 8; write them between texts.
// Timing:
//   A byte is registered at accept and resolved from the input register; an end
//   byte sets m_valid through the result register once that register is free.
//   One byte is taken every cycle while no end byte is held; the per-phase run
//   update is one read-modify-write of a MAX_PATTERN-entry register file, which sets that rate.
// Reset and stall:
//   aresetn (synchronous, low) clears all text state and sets the registers to
//   an all-zero pattern of length one. While a result waits for m_ready, bytes
//   that do not end a text still flow; a second end byte is held in the input
//   register, and s_ready drops only then.
// ---------------------------------------------------------------------------
`default_nettype none
`include "longest_pattern_repeat_run_core_macros.svh"

module longest_pattern_repeat_run_core #(
    parameter int MAX_PATTERN = 8,
    parameter int MAX_TEXT    = 65536
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // text in
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [lprr_pkg::BYTE_W-1:0]         s_text_byte,
    input  wire logic                                s_end_of_text,
    // result out
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [lprr_pkg::RUN_W-1:0]               m_best_run,
    output logic [lprr_pkg::START_OUT_W-1:0]         m_best_start,
    output logic                                     m_run_found,
    output logic                                     m_length_overflow,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lprr_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [lprr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lprr_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int CNT_W   = $clog2(MAX_TEXT + 1);
    localparam int START_W = $clog2(MAX_TEXT);
    localparam int PH_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W   = lprr_pkg::LEN_W;
    localparam int RUN_W   = lprr_pkg::RUN_W;
    localparam int SOUT_W  = lprr_pkg::START_OUT_W;

    // ---------------- configuration registers ----------------
    logic [lprr_pkg::PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0]           len_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            len_reg     <= LEN_W'(1);
        end else if (cfg_wr) begin
            case (paddr[3])
                lprr_pkg::REG_PATTERN: pattern_reg <= pwdata;
                lprr_pkg::REG_LENGTH:  len_reg     <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            lprr_pkg::REG_PATTERN: prdata = pattern_reg;
            lprr_pkg::REG_LENGTH:  prdata = {{(lprr_pkg::APB_DATA_W-LEN_W){1'b0}}, len_reg};
            default:               prdata = '0;
        endcase
    end

    logic [LEN_W-1:0] eff_len;
    logic [PH_W-1:0]  len_idx;

    // zero acts as one, anything past the maximum acts as the maximum
    always_comb begin
        if (len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (len_reg > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = len_reg;
        end
    end

    always_comb begin
        logic [LEN_W-1:0] lm1;
        lm1     = eff_len - LEN_W'(1);
        len_idx = lm1[PH_W-1:0];
    end

    // ---------------- input register ----------------
    logic                       in_valid_reg;
    logic [lprr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_eot_reg;
    logic                       advance;

    // an end byte needs the result register free
    assign advance = in_valid_reg && !(in_eot_reg && m_valid && !m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

    // ---------------- text state ----------------
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   best_count_reg;
    logic [START_W-1:0] best_pos_reg;
    logic               ovf_reg;
    logic [CNT_W-1:0]   cnt_reg   [MAX_PATTERN];
    logic [START_W-1:0] start_reg [MAX_PATTERN];
    logic [PH_W-1:0]    ph_cnt_reg  [MAX_PATTERN];
    logic [PH_W-1:0]    ph_cnt_next [MAX_PATTERN];

    logic               room;
    logic               take;
    logic               clear;
    logic               match;
    logic               hit;
    logic [CNT_W-1:0]   pos_next;
    logic [PH_W-1:0]    ph;
    logic [CNT_W-1:0]   cnt_cur;
    logic [CNT_W-1:0]   cnt_inc;
    logic [START_W-1:0] start_new;
    logic               best_upd;
    logic [CNT_W-1:0]   best_count_now;
    logic [START_W-1:0] best_pos_now;
    logic               ovf_now;

    assign room  = pos_reg < CNT_W'(MAX_TEXT);
    assign take  = advance && room;
    assign clear = advance && in_eot_reg;

    // one phase counter per pattern length; counter k runs modulo k+1
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_phase
        assign ph_cnt_next[k] = (ph_cnt_reg[k] == PH_W'(k)) ? '0
                                                             : ph_cnt_reg[k] + PH_W'(1);
    end

    lprr_pkg::win_ctl_t win_ctl;
    assign win_ctl.shift = take;
    assign win_ctl.clear = clear;

    lprr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .byte_in (in_byte_reg),
        .pattern (pattern_reg),
        .eff_len (eff_len),
        .match   (match)
    );

    assign pos_next  = pos_reg + CNT_W'(1);
    assign ph        = ph_cnt_next[len_idx];
    assign hit       = (pos_next >= CNT_W'(eff_len)) && match;
    assign cnt_cur   = cnt_reg[ph];
    assign cnt_inc   = cnt_cur + CNT_W'(1);
    assign start_new = (cnt_cur == '0)
                     ? START_W'(pos_reg) + START_W'(1) - START_W'(eff_len)
                     : start_reg[ph];
    assign best_upd  = take && hit && (cnt_inc > best_count_reg);

    assign best_count_now = best_upd ? cnt_inc   : best_count_reg;
    assign best_pos_now   = best_upd ? start_new : best_pos_reg;
    assign ovf_now        = ovf_reg || (advance && !room);

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pos_reg        <= '0;
            best_count_reg <= '0;
            best_pos_reg   <= '0;
            ovf_reg        <= 1'b0;
            for (int i = 0; i < MAX_PATTERN; i++) begin
                cnt_reg[i]    <= '0;
                ph_cnt_reg[i] <= '0;
            end
        end else if (advance) begin
            best_count_reg <= best_count_now;
            best_pos_reg   <= best_pos_now;
            ovf_reg        <= ovf_now;
            if (room) begin
                pos_reg     <= pos_next;
                ph_cnt_reg  <= ph_cnt_next;
                cnt_reg[ph] <= hit ? cnt_inc : '0;
            end
        end
    end

    // a start is read only while its count is nonzero, so it needs no reset
    always_ff @(posedge aclk) begin
        if (take && hit) begin
            start_reg[ph] <= start_new;
        end
    end

    // ---------------- result register ----------------
    logic [RUN_W+CNT_W-1:0]    run_wide;
    logic [SOUT_W+START_W-1:0] start_wide;

    assign run_wide   = {{RUN_W{1'b0}}, best_count_now};
    assign start_wide = {{SOUT_W{1'b0}}, best_pos_now};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (clear) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            m_best_run        <= run_wide[RUN_W-1:0];
            m_best_start      <= start_wide[SOUT_W-1:0];
            m_run_found       <= best_count_now != '0;
            m_length_overflow <= ovf_now;
        end
    end

    // ---------------- checks ----------------
    `LPRR_ASSERT_NOW(a_ready_only_on_stall, aclk, aresetn, !s_ready, in_valid_reg && in_eot_reg && m_valid && !m_ready)
    `LPRR_ASSERT_NOW(a_empty_result_zero, aclk, aresetn, m_valid && !m_run_found, m_best_run == '0 && m_best_start == '0)
    `LPRR_ASSERT_NEXT(a_text_cleared, aclk, aresetn, clear, pos_reg == '0 && best_count_reg == '0 && !ovf_reg && m_valid)
    `LPRR_ASSERT_NOW(a_pos_bounded, aclk, aresetn, in_valid_reg, pos_reg <= CNT_W'(MAX_TEXT))

endmodule

`default_nettype wire
